@@ rtl/ttc_pkg.sv @@
// Package for the trajectory tracking controller.
// Holds shared constants, the CORDIC arc table and register indexes; no dependencies.
package ttc_pkg;

  localparam int unsigned TableLen = 24;
  localparam logic signed [63:0] CordicGainQ30 = 64'sd652032874;
  localparam logic signed [31:0] InvTwoPiQ16   = 32'sd10430;

  localparam logic [1:0] KindStart  = 2'd0;
  localparam logic [1:0] KindSecond = 2'd1;
  localparam logic [1:0] KindTrack  = 2'd2;

  localparam logic [1:0] RegGainVel = 2'd0;
  localparam logic [1:0] RegGainPos = 2'd1;
  localparam logic [1:0] RegStepT   = 2'd2;
  localparam logic [1:0] RegStepR   = 2'd3;

  // arctangent of 2^-i in heading units
  function automatic logic signed [15:0] arc_lut(input logic [4:0] i);
    case (i)
      5'd0:  arc_lut = 16'sd8192;
      5'd1:  arc_lut = 16'sd4836;
      5'd2:  arc_lut = 16'sd2555;
      5'd3:  arc_lut = 16'sd1297;
      5'd4:  arc_lut = 16'sd651;
      5'd5:  arc_lut = 16'sd326;
      5'd6:  arc_lut = 16'sd163;
      5'd7:  arc_lut = 16'sd81;
      5'd8:  arc_lut = 16'sd41;
      5'd9:  arc_lut = 16'sd20;
      5'd10: arc_lut = 16'sd10;
      5'd11: arc_lut = 16'sd5;
      5'd12: arc_lut = 16'sd3;
      5'd13: arc_lut = 16'sd1;
      5'd14: arc_lut = 16'sd1;
      default: arc_lut = 16'sd0;
    endcase
  endfunction

  // saturate a 64 bit value to signed 32 bit
  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) sat32 = 32'sh7fffffff;
    else if (v < -64'sd2147483648) sat32 = 32'sh80000000;
    else sat32 = v[31:0];
  endfunction

endpackage

@@ rtl/ttc_cordic.sv @@
// Iterative CORDIC unit: rotation (sin/cos of a heading) or vectoring (heading of a vector).
// One micro-rotation per cycle. Depends on ttc_pkg.
module ttc_cordic import ttc_pkg::*; #(
  parameter int unsigned CordicSteps = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic               vec_i,
  input  logic        [15:0] ang_i,
  input  logic signed [32:0] dx_i,
  input  logic signed [32:0] dy_i,
  output logic               done_o,
  output logic signed [31:0] cos_o,
  output logic signed [31:0] sin_o,
  output logic        [15:0] ang_o
);

  localparam int unsigned NSteps = (CordicSteps > TableLen) ? TableLen : CordicSteps;

  logic signed [63:0] x_q, x_d, y_q, y_d;
  logic signed [31:0] z_q, z_d;
  logic [4:0] i_q, i_d;
  logic busy_q, busy_d, vec_q, vec_d, flip_q, flip_d, zero_q, zero_d, done_q, done_d;

  logic [15:0] a_rot;
  logic signed [63:0] xs, ys, ex, ey;
  logic dir;

  always_comb begin
    a_rot = ang_i;
    if (((ang_i + 16'd16384) & 16'h8000) != 16'd0) a_rot = ang_i ^ 16'h8000;
    xs = x_q >>> i_q;
    ys = y_q >>> i_q;
    dir = vec_q ? (y_q <= 0) : (z_q >= 0);
    x_d = x_q; y_d = y_q; z_d = z_q; i_d = i_q; busy_d = busy_q;
    vec_d = vec_q; flip_d = flip_q; zero_d = zero_q; done_d = 1'b0;
    if (start_i) begin
      busy_d = 1'b1; i_d = '0; vec_d = vec_i;
      if (vec_i) begin
        ex = 64'(dx_i) <<< 20; ey = 64'(dy_i) <<< 20;
        zero_d = (dx_i == 0) && (dy_i == 0);
        flip_d = 1'b0;
        if (ex < 0) begin
          x_d = -ex; y_d = -ey; z_d = 32'sd32768;
        end else begin
          x_d = ex; y_d = ey; z_d = '0;
        end
      end else begin
        ex = '0; ey = '0;
        zero_d = 1'b0;
        flip_d = ((ang_i + 16'd16384) & 16'h8000) != 16'd0;
        x_d = CordicGainQ30; y_d = '0;
        z_d = 32'(signed'(a_rot));
      end
      if (NSteps == 0) begin
        busy_d = 1'b0; done_d = 1'b1;
      end
    end else begin
      ex = '0; ey = '0;
      if (busy_q) begin
        if (dir) begin
          x_d = x_q - ys; y_d = y_q + xs; z_d = z_q - 32'(arc_lut(i_q));
        end else begin
          x_d = x_q + ys; y_d = y_q - xs; z_d = z_q + 32'(arc_lut(i_q));
        end
        i_d = i_q + 5'd1;
        if (32'(i_q) == NSteps - 1) begin
          busy_d = 1'b0; done_d = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; done_q <= 1'b0; i_q <= '0;
    end else begin
      busy_q <= busy_d; done_q <= done_d; i_q <= i_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d; y_q <= y_d; z_q <= z_d;
    vec_q <= vec_d; flip_q <= flip_d; zero_q <= zero_d;
  end

  logic signed [63:0] xf, yf;
  assign xf = flip_q ? -x_q : x_q;
  assign yf = flip_q ? -y_q : y_q;
  assign cos_o = sat32(xf >>> 14);
  assign sin_o = sat32(yf >>> 14);
  assign ang_o = zero_q ? 16'd0 : z_q[15:0];
  assign done_o = done_q;

endmodule

@@ rtl/ttc_divider.sv @@
// Restoring divider: 64 bit signed dividend by 32 bit signed divisor, truncating.
// One quotient bit per cycle. Depends on ttc_pkg.
module ttc_divider import ttc_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic signed [63:0] num_i,
  input  logic signed [31:0] den_i,
  output logic               done_o,
  output logic signed [31:0] quo_o
);

  logic [63:0] q_q, q_d;
  logic [32:0] r_q, r_d;
  logic [31:0] d_q, d_d;
  logic [6:0] n_q, n_d;
  logic neg_q, neg_d, busy_q, busy_d, done_q, done_d;
  logic [33:0] sh, diff;
  logic [63:0] qabs;
  logic signed [64:0] qs;

  always_comb begin
    q_d = q_q; r_d = r_q; d_d = d_q; n_d = n_q; neg_d = neg_q;
    busy_d = busy_q; done_d = 1'b0;
    sh = {r_q, q_q[63]};
    diff = sh - {2'b0, d_q};
    if (start_i) begin
      q_d = num_i[63] ? 64'(-num_i) : num_i;
      d_d = den_i[31] ? 32'(-den_i) : den_i;
      neg_d = num_i[63] ^ den_i[31];
      r_d = '0; n_d = '0; busy_d = 1'b1;
    end else if (busy_q) begin
      if (!diff[33]) begin
        r_d = diff[32:0]; q_d = {q_q[62:0], 1'b1};
      end else begin
        r_d = sh[32:0]; q_d = {q_q[62:0], 1'b0};
      end
      n_d = n_q + 7'd1;
      if (n_q == 7'd63) begin
        busy_d = 1'b0; done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; done_q <= 1'b0; n_q <= '0;
    end else begin
      busy_q <= busy_d; done_q <= done_d; n_q <= n_d;
    end
  end

  always_ff @(posedge clk_i) begin
    q_q <= q_d; r_q <= r_d; d_q <= d_d; neg_q <= neg_d;
  end

  assign qabs = q_q;
  assign qs = neg_q ? -$signed({1'b0, qabs}) : $signed({1'b0, qabs});
  assign quo_o = sat32(qs[64] ? (qs < -65'sd9223372036854775807 ? 64'sh8000000000000000
                                                                  : qs[63:0])
                              : (qs[63] ? 64'sh7fffffffffffffff : qs[63:0]));
  assign done_o = done_q;

endmodule

@@ rtl/trajectory_tracking_controller.sv @@
// Trajectory tracking controller top level: sequencer, shared multiplier, state.
// Uses ttc_pkg, ttc_cordic and ttc_divider.
//
// One transaction in, one result out. A tracking step runs two CORDIC rotations,
// twenty products on the one shared 33x33 multiplier (four-product groups
// pipelined) and a divide for the turn command; a zero speed command skips the
// divide. A second waypoint takes one CORDIC vectoring run; a start waypoint or
// an unused kind goes straight to the result.
// in_ready_o is low while an item is in work or its result waits to be taken.
module trajectory_tracking_controller import ttc_pkg::*; #(
  parameter int unsigned CORDIC_STEPS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  kind_i,
  input  logic signed [31:0] ref_x_i,
  input  logic signed [31:0] ref_y_i,
  input  logic signed [31:0] meas_speed_i,
  input  logic signed [31:0] meas_turn_rate_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic signed [31:0] speed_cmd_o,
  output logic signed [31:0] turn_cmd_o,
  output logic signed [31:0] pose_x_o,
  output logic signed [31:0] pose_y_o,
  output logic        zero_speed_o,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [23:0] cfg_data_i
);

  // sequencer codes
  localparam logic [4:0] SIdle = 5'd0,  SVec = 5'd1,  SVecW = 5'd2,  SVel = 5'd3,
                         SDel = 5'd4,  SPhi = 5'd5,  SDh = 5'd6,   SRot1 = 5'd7,
                         SRot1W = 5'd8, SPx = 5'd9, SPy = 5'd10, SRot2 = 5'd11,
                         SRot2W = 5'd12, SVx = 5'd13, SVy = 5'd14, SAx = 5'd15,
                         SAy = 5'd16, SVc = 5'd17, SVs = 5'd18, SEx = 5'd19,
                         SEy = 5'd20, SA1 = 5'd21, SA2 = 5'd22, SSpd = 5'd23,
                         SDiv = 5'd24, SDivW = 5'd25, SOut = 5'd26, SGain = 5'd27;

  logic [4:0] st_q, st_d;
  logic [3:0] sub_q, sub_d;

  // configuration
  logic [15:0] gv_q, gp_q;
  logic [23:0] tst_q, trt_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gv_q <= 16'd1280; gp_q <= 16'd256; tst_q <= 24'd16384; trt_q <= 24'd262144;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegGainVel: gv_q <= cfg_data_i[15:0];
        RegGainPos: gp_q <= cfg_data_i[15:0];
        RegStepT:   tst_q <= cfg_data_i;
        RegStepR:   trt_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // item registers and state
  logic [1:0] kind_q;
  logic signed [31:0] rx_q, ry_q, v_q, w_q;
  logic signed [31:0] px_q, py_q, prx_q, pry_q, pvx_q, pvy_q, si_q;
  logic [15:0] hd_q;
  logic signed [31:0] t0_q, t1_q, t2_q, t3_q, c_q, s_q, ex_q, ey_q, ax_q, ay_q, a2_q;
  logic signed [31:0] vxs_q, vys_q, turn_q;
  logic signed [63:0] acc_q;
  logic zf_q, ovalid_q;

  // shared multiplier: 33 x 33 signed, registered product
  logic signed [32:0] ma, mb;
  logic signed [65:0] prod_q;
  always_ff @(posedge clk_i) prod_q <= ma * mb;

  logic signed [63:0] p16, p8;
  assign p16 = 64'(prod_q >>> 16);
  assign p8  = 64'(prod_q >>> 8);

  // 33 bit differences (may exceed 32 bits before saturation)
  logic signed [32:0] dxr, dyr, dvx, dvy;
  assign dxr = 33'(rx_q) - 33'(prx_q);
  assign dyr = 33'(ry_q) - 33'(pry_q);
  assign dvx = 33'(vxs_q) - 33'(pvx_q);
  assign dvy = 33'(vys_q) - 33'(pvy_q);

  // CORDIC and divider
  logic cs_start, cs_vec, cs_done, dv_start, dv_done;
  logic [15:0] cs_ang, cs_ango, mid;
  logic signed [31:0] cs_cos, cs_sin, dv_quo;

  ttc_cordic #(.CordicSteps(CORDIC_STEPS)) u_cordic (
    .clk_i, .rst_ni, .start_i(cs_start), .vec_i(cs_vec), .ang_i(cs_ang),
    .dx_i(dxr), .dy_i(dyr), .done_o(cs_done), .cos_o(cs_cos), .sin_o(cs_sin),
    .ang_o(cs_ango)
  );

  ttc_divider u_div (
    .clk_i, .rst_ni, .start_i(dv_start), .num_i(64'(a2_q) <<< 16), .den_i(si_q),
    .done_o(dv_done), .quo_o(dv_quo)
  );

  assign mid = hd_q + 16'(t2_q >>> 1);
  assign cs_ang = (st_q == SRot1) ? mid : hd_q;
  assign cs_vec = (st_q == SVec);
  assign cs_start = (st_q == SVec) || (st_q == SRot1) || (st_q == SRot2);
  assign dv_start = (st_q == SDiv);

  assign in_ready_o = (st_q == SIdle) && !ovalid_q;

  // multiplier operand select; in single-product states sub counts 0: issue, 1: result
  always_comb begin
    ma = '0; mb = '0;
    unique case (st_q)
      SVel: begin
        ma = (sub_q == 4'd0) ? dxr : dyr; mb = 33'(trt_q);
      end
      SDel: begin ma = 33'(v_q); mb = 33'(tst_q); end
      SPhi: begin ma = 33'(w_q); mb = 33'(tst_q); end
      SDh:  begin ma = 33'(t1_q); mb = 33'(InvTwoPiQ16); end
      SPx:  begin ma = 33'(t0_q); mb = 33'(c_q); end
      SPy:  begin ma = 33'(t0_q); mb = 33'(s_q); end
      SVx:  begin ma = dxr; mb = 33'(trt_q); end
      SVy:  begin ma = dyr; mb = 33'(trt_q); end
      SAx:  begin ma = dvx; mb = 33'(trt_q); end
      SAy:  begin ma = dvy; mb = 33'(trt_q); end
      SVc:  begin ma = 33'(v_q); mb = 33'(c_q); end
      SVs:  begin ma = 33'(v_q); mb = 33'(s_q); end
      SGain: begin
        unique case (sub_q)
          4'd0: begin ma = 33'(gv_q); mb = 33'(ex_q); end
          4'd1: begin ma = 33'(gp_q); mb = 33'(t0_q); end
          4'd2: begin ma = 33'(gv_q); mb = 33'(ey_q); end
          default: begin ma = 33'(gp_q); mb = 33'(t1_q); end
        endcase
      end
      SA1: begin
        ma = 33'(c_q); mb = (sub_q[0] == 1'b0) ? 33'(ax_q) : 33'(ay_q);
        if (sub_q[1]) ma = 33'(s_q);
      end
      SSpd: begin ma = 33'(t3_q); mb = 33'(tst_q); end
      default: ;
    endcase
  end

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= SIdle; sub_q <= '0; ovalid_q <= 1'b0;
      px_q <= '0; py_q <= '0; prx_q <= '0; pry_q <= '0;
      pvx_q <= '0; pvy_q <= '0; si_q <= '0; hd_q <= '0;
    end else begin
      if (ovalid_q && out_ready_i) ovalid_q <= 1'b0;
      unique case (st_q)
        SIdle: if (in_valid_i && in_ready_o) begin
          kind_q <= kind_i; rx_q <= ref_x_i; ry_q <= ref_y_i;
          v_q <= meas_speed_i; w_q <= meas_turn_rate_i;
          sub_q <= '0; zf_q <= 1'b0; turn_q <= '0;
          unique case (kind_i)
            KindStart: st_q <= SOut;
            KindSecond: st_q <= SVec;
            KindTrack: st_q <= SDel;
            default: st_q <= SOut;
          endcase
        end
        SVec: st_q <= SVecW;
        SVecW: if (cs_done) begin hd_q <= cs_ango; st_q <= SVel; end
        SVel: begin
          sub_q <= sub_q + 4'd1;
          if (sub_q == 4'd1) pvx_q <= sat32(p16);
          if (sub_q == 4'd2) begin pvy_q <= sat32(p16); st_q <= SOut; end
        end
        SDel, SPhi, SDh, SPx, SPy, SVx, SVy, SAx, SAy, SVc, SVs, SSpd: begin
          if (sub_q == 4'd0) sub_q <= 4'd1;
          else begin
            sub_q <= '0;
            unique case (st_q)
              SDel: begin t0_q <= sat32(p16); st_q <= SPhi; end
              SPhi: begin t1_q <= sat32(p16); st_q <= SDh; end
              SDh:  begin t2_q <= 32'(p16); st_q <= SRot1; end
              SPx: begin px_q <= sat32(64'(px_q) + 64'(sat32(p16))); st_q <= SPy; end
              SPy: begin
                py_q <= sat32(64'(py_q) + 64'(sat32(p16)));
                hd_q <= hd_q + t2_q[15:0]; st_q <= SRot2;
              end
              SVx: begin vxs_q <= sat32(p16); st_q <= SVy; end
              SVy: begin vys_q <= sat32(p16); st_q <= SAx; end
              SAx: begin ax_q <= sat32(p16); st_q <= SAy; end
              SAy: begin ay_q <= sat32(p16); st_q <= SVc; end
              SVc: begin ex_q <= sat32(64'(vxs_q) - 64'(sat32(p16))); st_q <= SVs; end
              SVs: begin ey_q <= sat32(64'(vys_q) - 64'(sat32(p16))); st_q <= SEx; end
              default: begin
                si_q <= sat32(64'(si_q) + 64'(sat32(p16)));
                st_q <= SDiv;
              end
            endcase
          end
        end
        SRot1: st_q <= SRot1W;
        SRot1W: if (cs_done) begin c_q <= cs_cos; s_q <= cs_sin; st_q <= SPx; end
        SRot2: st_q <= SRot2W;
        SRot2W: if (cs_done) begin c_q <= cs_cos; s_q <= cs_sin; st_q <= SVx; end
        // position errors into t0/t1; ex/ey hold velocity errors
        SEx: begin t0_q <= sat32(64'(rx_q) - 64'(px_q)); st_q <= SEy; end
        SEy: begin t1_q <= sat32(64'(ry_q) - 64'(py_q)); st_q <= SGain; sub_q <= '0; end
        SGain: begin
          sub_q <= sub_q + 4'd1;
          if (sub_q == 4'd1) acc_q <= 64'(ax_q) + p8;
          if (sub_q == 4'd2) ax_q <= sat32(acc_q + p8);
          if (sub_q == 4'd3) acc_q <= 64'(ay_q) + p8;
          if (sub_q == 4'd4) begin
            ay_q <= sat32(acc_q + p8); st_q <= SA1; sub_q <= '0;
          end
        end
        // products c*ax, c*ay, s*ax, s*ay; a1 = c*ax + s*ay
        SA1: begin
          sub_q <= sub_q + 4'd1;
          if (sub_q == 4'd1) acc_q <= p16;
          if (sub_q == 4'd4) begin
            t3_q <= sat32(acc_q + p16);
            st_q <= SA2; sub_q <= '0;
          end
        end
        SA2: st_q <= SSpd;
        SDiv: begin
          if (si_q == 0) begin zf_q <= 1'b1; st_q <= SOut; end
          else st_q <= SDivW;
        end
        SDivW: if (dv_done) begin turn_q <= dv_quo; st_q <= SOut; end
        SOut: begin
          if (kind_q == KindStart) begin
            px_q <= rx_q; py_q <= ry_q; prx_q <= rx_q; pry_q <= ry_q;
            pvx_q <= '0; pvy_q <= '0; hd_q <= '0; si_q <= '0;
          end else if (kind_q == KindSecond) begin
            prx_q <= rx_q; pry_q <= ry_q;
          end else if (kind_q == KindTrack) begin
            prx_q <= rx_q; pry_q <= ry_q; pvx_q <= vxs_q; pvy_q <= vys_q;
          end
          ovalid_q <= 1'b1; st_q <= SIdle;
        end
        default: st_q <= SIdle;
      endcase
    end
  end

  // a2 = c*ay - s*ax, held separately: c*ay product at sub 2, s*ax at sub 3
  logic signed [63:0] cay_q;
  always_ff @(posedge clk_i) begin
    if (st_q == SA1 && sub_q == 4'd2) cay_q <= p16;
    if (st_q == SA1 && sub_q == 4'd3) a2_q <= sat32(cay_q - p16);
  end

  assign out_valid_o  = ovalid_q;
  assign speed_cmd_o  = (kind_q == KindTrack) ? si_q : 32'sd0;
  assign turn_cmd_o   = (kind_q == KindTrack && !zf_q) ? turn_q : 32'sd0;
  assign pose_x_o     = px_q;
  assign pose_y_o     = py_q;
  assign zero_speed_o = (kind_q == KindTrack) && zf_q;

endmodule

@@ rtl/ttc_checker.sv @@
// Port-level checker for the trajectory tracking controller, bound to the top level.
// Depends on trajectory_tracking_controller ports only.
module ttc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic        zero_speed_o,
  input logic [31:0] speed_cmd_o,
  input logic [31:0] turn_cmd_o
);

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o) else $error("ready after accept");

  a_no_in_while_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !in_ready_o) else $error("ready with pending result");

  a_zero_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && zero_speed_o |-> speed_cmd_o == 32'd0 && turn_cmd_o == 32'd0)
    else $error("zero flag inconsistent");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(speed_cmd_o))
    else $error("result dropped");

endmodule

bind trajectory_tracking_controller ttc_checker u_ttc_checker (
  .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .out_valid_o, .out_ready_i,
  .zero_speed_o, .speed_cmd_o, .turn_cmd_o
);

@@ tb/trajectory_tracking_controller_tb.sv @@
// Testbench for the trajectory tracking controller: drives waypoint and tracking
// transactions, predicts every result in a scoreboard class. Depends on ttc_pkg and the RTL.
`timescale 1ns / 1ps

module trajectory_tracking_controller_tb;
  import ttc_pkg::*;

  localparam int unsigned Steps = 16;
  localparam int unsigned WatchLimit = 20000;

  typedef struct packed {
    logic signed [31:0] speed;
    logic signed [31:0] turn;
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic               zflag;
  } cmd_t;

  // Controller predictor plus queue of expected commands
  class ctrl_scoreboard;
    logic [15:0] g_vel, g_pos;
    logic [23:0] t_step, r_step;
    logic signed [31:0] px, py, wx, wy, wvx, wvy, spd_int;
    logic [15:0] hdg;
    cmd_t pending[$];
    int errors;
    int checked;

    function new();
      g_vel = 16'd1280; g_pos = 16'd256; t_step = 24'd16384; r_step = 24'd262144;
      px = 0; py = 0; wx = 0; wy = 0; wvx = 0; wvy = 0; spd_int = 0; hdg = 0;
      errors = 0; checked = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [23:0] val);
      case (idx)
        RegGainVel: g_vel = val[15:0];
        RegGainPos: g_pos = val[15:0];
        RegStepT:   t_step = val;
        default:    r_step = val;
      endcase
    endfunction

    function logic signed [31:0] clip(logic signed [63:0] v);
      if (v > 64'sd2147483647) return 32'sh7fffffff;
      if (v < -64'sd2147483648) return 32'sh80000000;
      return v[31:0];
    endfunction

    function logic signed [63:0] fmul(logic signed [63:0] a, logic signed [63:0] b);
      return (a * b) >>> 16;
    endfunction

    function logic signed [63:0] arc(int i);
      int tbl[15] = '{8192, 4836, 2555, 1297, 651, 326, 163, 81, 41, 20, 10, 5, 3, 1, 1};
      return (i < 15) ? tbl[i] : 0;
    endfunction

    function void rotate(logic [15:0] ang, output logic signed [31:0] c,
                         output logic signed [31:0] s);
      logic signed [63:0] x, y, z, nx;
      logic flip;
      logic [15:0] a;
      logic [15:0] q;
      q = ang + 16'd16384;
      flip = q[15];
      a = flip ? (ang ^ 16'h8000) : ang;
      x = 64'sd652032874; y = 0;
      z = $signed({{48{a[15]}}, a});
      for (int i = 0; i < Steps; i++) begin
        if (z >= 0) begin
          nx = x - (y >>> i); y = y + (x >>> i); z = z - arc(i);
        end else begin
          nx = x + (y >>> i); y = y - (x >>> i); z = z + arc(i);
        end
        x = nx;
      end
      if (flip) begin
        x = -x; y = -y;
      end
      c = clip(x >>> 14);
      s = clip(y >>> 14);
    endfunction

    function logic [15:0] bearing(logic signed [63:0] dx, logic signed [63:0] dy);
      logic signed [63:0] x, y, z, nx;
      if (dx == 0 && dy == 0) return 16'd0;
      x = dx * 64'sd1048576; y = dy * 64'sd1048576; z = 0;
      if (x < 0) begin
        x = -x; y = -y; z = 32768;
      end
      for (int i = 0; i < Steps; i++) begin
        if (y > 0) begin
          nx = x + (y >>> i); y = y - (x >>> i); z = z + arc(i);
        end else begin
          nx = x - (y >>> i); y = y + (x >>> i); z = z - arc(i);
        end
        x = nx;
      end
      return z[15:0];
    endfunction

    // Note an accepted input transaction and queue its expected command
    function void note_input(logic [1:0] kind, logic signed [31:0] rx,
                             logic signed [31:0] ry, logic signed [31:0] v,
                             logic signed [31:0] w);
      cmd_t r;
      logic signed [63:0] dx, dy, dh, tt, rr, quo, gv, gp;
      logic signed [31:0] delta, phi, c, s, vxs, vys, axs, ays, ex, ey, evx, evy;
      logic signed [31:0] ax, ay, a1, a2;
      logic signed [63:0] sum;
      r = '0;
      tt = {40'd0, t_step};
      rr = {40'd0, r_step};
      gv = {48'd0, g_vel};
      gp = {48'd0, g_pos};
      dx = 64'(rx) - 64'(wx);
      dy = 64'(ry) - 64'(wy);
      if (kind == KindStart) begin
        px = rx; py = ry; wx = rx; wy = ry; wvx = 0; wvy = 0; hdg = 0; spd_int = 0;
      end else if (kind == KindSecond) begin
        hdg = bearing(dx, dy);
        wvx = clip(fmul(dx, rr));
        wvy = clip(fmul(dy, rr));
        wx = rx; wy = ry;
      end else if (kind == KindTrack) begin
        delta = clip(fmul(v, tt));
        phi = clip(fmul(w, tt));
        dh = (64'(phi) * 64'sd10430) >>> 16;
        rotate(hdg + 16'(dh >>> 1), c, s);
        px = clip(64'(px) + 64'(clip(fmul(delta, c))));
        py = clip(64'(py) + 64'(clip(fmul(delta, s))));
        hdg = hdg + 16'(dh);
        rotate(hdg, c, s);
        vxs = clip(fmul(dx, rr));
        vys = clip(fmul(dy, rr));
        axs = clip(fmul(64'(vxs) - 64'(wvx), rr));
        ays = clip(fmul(64'(vys) - 64'(wvy), rr));
        ex = clip(64'(rx) - 64'(px));
        ey = clip(64'(ry) - 64'(py));
        evx = clip(64'(vxs) - 64'(clip(fmul(v, c))));
        evy = clip(64'(vys) - 64'(clip(fmul(v, s))));
        sum = 64'(axs) + ((gv * 64'(evx)) >>> 8) + ((gp * 64'(ex)) >>> 8);
        ax = clip(sum);
        sum = 64'(ays) + ((gv * 64'(evy)) >>> 8) + ((gp * 64'(ey)) >>> 8);
        ay = clip(sum);
        a1 = clip(fmul(c, ax) + fmul(s, ay));
        a2 = clip(fmul(c, ay) - fmul(s, ax));
        spd_int = clip(64'(spd_int) + 64'(clip(fmul(a1, tt))));
        r.speed = spd_int;
        if (spd_int == 0) r.zflag = 1'b1;
        else begin
          quo = (64'(a2) * 64'sd65536) / 64'(spd_int);
          r.turn = clip(quo);
        end
        wx = rx; wy = ry; wvx = vxs; wvy = vys;
      end
      r.px = px;
      r.py = py;
      pending.push_back(r);
    endfunction

    // Compare one accepted result against the oldest expectation
    function void check_result(cmd_t got);
      cmd_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result speed %0d turn %0d", $time, got.speed, got.turn);
        errors++;
        return;
      end
      e = pending.pop_front();
      checked++;
      if (got.speed !== e.speed) begin
        $display("%0t: speed_cmd exp %0d got %0d", $time, e.speed, got.speed); errors++;
      end
      if (got.turn !== e.turn) begin
        $display("%0t: turn_cmd exp %0d got %0d", $time, e.turn, got.turn); errors++;
      end
      if (got.px !== e.px) begin
        $display("%0t: pose_x exp %0d got %0d", $time, e.px, got.px); errors++;
      end
      if (got.py !== e.py) begin
        $display("%0t: pose_y exp %0d got %0d", $time, e.py, got.py); errors++;
      end
      if (got.zflag !== e.zflag) begin
        $display("%0t: zero_speed exp %0b got %0b", $time, e.zflag, got.zflag); errors++;
      end
    endfunction
  endclass

  logic clk_i, rst_ni;
  logic in_valid_i, in_ready_o, out_valid_o, out_ready_i;
  logic [1:0] kind_i;
  logic signed [31:0] ref_x_i, ref_y_i, meas_speed_i, meas_turn_rate_i;
  logic signed [31:0] speed_cmd_o, turn_cmd_o, pose_x_o, pose_y_o;
  logic zero_speed_o;
  logic cfg_we_i;
  logic [1:0] cfg_idx_i;
  logic [23:0] cfg_data_i;

  ctrl_scoreboard sb;
  int idle_cycles;
  bit hold_off;
  int kind_count[4];

  trajectory_tracking_controller #(.CORDIC_STEPS(Steps)) dut (.*);

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 50) return 0;
    if (p < 92) return $urandom_range(1, 4);
    return $urandom_range(10, 60);
  endfunction

  function automatic logic signed [31:0] rand_q(int mode);
    case (mode)
      0: return $urandom;
      1: return $signed($urandom_range(0, 32'h000fffff)) - 32'sh00080000;
      default: return $signed($urandom_range(0, 32'h00003fff)) - 32'sh00002000;
    endcase
  endfunction

  task automatic send_item(logic [1:0] kind, logic signed [31:0] rx, logic signed [31:0] ry,
                           logic signed [31:0] v, logic signed [31:0] w);
    in_valid_i <= 1'b1;
    kind_i <= kind; ref_x_i <= rx; ref_y_i <= ry; meas_speed_i <= v; meas_turn_rate_i <= w;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_input(kind, rx, ry, v, w);
    kind_count[kind]++;
    repeat (gap_len()) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
  endtask

  task automatic write_cfg(logic [1:0] idx, logic [23:0] val);
    in_valid_i <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    cfg_we_i <= 1'b1; cfg_idx_i <= idx; cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.write_reg(idx, val);
  endtask

  // Random trajectory: start, second waypoint, then tracking steps with random content, some of them random kinds
  task automatic run_path(int len, int mode);
    logic signed [31:0] x, y;
    x = rand_q(mode); y = rand_q(mode);
    send_item(KindStart, x, y, rand_q(0), rand_q(0));
    x = x + rand_q(2); y = y + rand_q(2);
    send_item(KindSecond, x, y, rand_q(0), rand_q(0));
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 19) == 0)
        send_item(2'($urandom_range(0, 3)), rand_q(0), rand_q(0), rand_q(0), rand_q(0));
      else begin
        x = x + rand_q(2); y = y + rand_q(2);
        send_item(KindTrack, x, y, rand_q(mode == 0 ? 0 : 2), rand_q(mode == 0 ? 0 : 2));
      end
    end
  endtask

  // Result side: random stalls plus one long hold-off
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i)
      sb.check_result('{speed_cmd_o, turn_cmd_o, pose_x_o, pose_y_o, zero_speed_o});
  end

  initial begin
    int g;
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (hold_off) begin
        out_ready_i <= 1'b0;
        repeat (600) @(posedge clk_i);
        hold_off = 1'b0;
      end
      out_ready_i <= 1'b1;
      @(posedge clk_i);
      g = gap_len();
      if (g > 0) begin
        out_ready_i <= 1'b0;
        repeat (g) @(posedge clk_i);
      end
    end
  end

  // Watchdog on cycles without any transaction
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || cfg_we_i)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WatchLimit) begin
      $display("FAIL trajectory_tracking_controller");
      $finish;
    end
  end

  initial begin
    logic [23:0] cfg_sets[4][4];
    sb = new();
    idle_cycles = 0; hold_off = 0;
    rst_ni = 1'b0; in_valid_i = 1'b0; kind_i = KindStart;
    ref_x_i = 0; ref_y_i = 0; meas_speed_i = 0; meas_turn_rate_i = 0;
    cfg_we_i = 1'b0; cfg_idx_i = RegGainVel; cfg_data_i = 0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: field extremes, coincident waypoints, zero speed, unused kind
    send_item(KindTrack, 0, 0, 0, 0);
    send_item(2'd3, 32'sh7fffffff, 32'sh80000000, 0, 0);
    send_item(KindStart, 32'sh7fffffff, 32'sh80000000, 0, 0);
    send_item(KindSecond, 32'sh7fffffff, 32'sh80000000, 0, 0);
    send_item(KindTrack, 32'sh80000000, 32'sh7fffffff, 32'sh7fffffff, 32'sh80000000);
    send_item(KindTrack, 32'sh7fffffff, 32'sh80000000, 32'sh80000000, 32'sh7fffffff);
    send_item(KindTrack, -1, -1, -1, -1);
    send_item(KindStart, 0, 0, 0, 0);
    send_item(KindSecond, 0, 32'sh00010000, 0, 0);
    send_item(KindTrack, 0, 32'sh00010000, 0, 0);
    send_item(KindTrack, 0, 32'sh00018000, 32'sh00010000, 32'sh00008000);
    send_item(KindStart, 32'sh00050000, 0, 0, 0);
    send_item(KindSecond, 32'sh00040000, 0, 0, 0);
    send_item(KindSecond, 32'sh00040000, -32'sh00010000, 0, 0);
    send_item(KindTrack, 32'sh00030000, -32'sh00010000, 32'sh00020000, -32'sh00030000);
    send_item(2'd3, 0, 0, 0, 0);

    // Long receiver hold-off while the sender keeps offering
    hold_off = 1'b1;
    run_path(20, 2);

    cfg_sets = '{'{24'd0, 24'd0, 24'd1, 24'd1},
                 '{24'hffff, 24'hffff, 24'hffffff, 24'hffffff},
                 '{24'd1280, 24'd256, 24'd16384, 24'd262144},
                 '{24'd0, 24'd0, 24'd0, 24'd0}};
    for (int ph = 0; ph < 6; ph++) begin
      for (int r = 0; r < 4; r++)
        write_cfg(2'(r), ph < 4 ? cfg_sets[ph][r] :
                  (r < 2 ? 24'($urandom_range(0, 16'hffff)) : 24'($urandom_range(1, 24'hffffff))));
      for (int p = 0; p < 10; p++) run_path($urandom_range(10, 50), $urandom_range(0, 2));
    end

    in_valid_i <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
    $display("Checked %0d results: %0d start, %0d second, %0d tracking, %0d unused kind.",
             sb.checked, kind_count[0], kind_count[1], kind_count[2], kind_count[3]);
    $display("Register sets covered zero, full-scale, default and random values.");
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("PASS trajectory_tracking_controller");
    end else begin
      $display("FAIL trajectory_tracking_controller");
    end
    $finish;
  end

endmodule

@@ trajectory_tracking_controller.f @@
rtl/ttc_pkg.sv
rtl/ttc_cordic.sv
rtl/ttc_divider.sv
rtl/trajectory_tracking_controller.sv
rtl/ttc_checker.sv
tb/trajectory_tracking_controller_tb.sv
